// ----- hdl/dsc_pkg.sv -----
package dsc_pkg;

   localparam int OP_W       = 3;
   localparam int STATE_W    = 3;
   localparam int ELAPSED_W  = 19;
   localparam int TIMEOUT_W  = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam int TICKS_PER_SECOND_DEF = 1000;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 9'd60;

   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_OPEN  = 3'd1;
   localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
   localparam logic [OP_W-1:0] OP_ABORT = 3'd3;
   localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

   localparam logic [STATE_W-1:0] ST_OPEN    = 3'd0;
   localparam logic [STATE_W-1:0] ST_CLOSED  = 3'd1;
   localparam logic [STATE_W-1:0] ST_OPENING = 3'd2;
   localparam logic [STATE_W-1:0] ST_CLOSING = 3'd3;
   localparam logic [STATE_W-1:0] ST_ERROR   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_MODE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_SECONDS = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            switch_closed;
      logic            switch_opened;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] shutter_state;
      logic               slewing;
      logic               relay_open;
      logic               relay_close;
      logic               accepted;
   } rsp_type;

   typedef struct packed {
      logic                 switch_mode;
      logic [TIMEOUT_W-1:0] timeout_seconds;
   } cfg_type;

endpackage

// ----- hdl/dome_shutter_controller.sv -----
// Shutter controller: takes one beat per clock while the result side is not stalled and returns
// one result beat per input beat, via an input register and then a result register. The state
// update and the timeout compare against timeout_seconds * TICKS_PER_SECOND sit between those two
// registers. Configuration writes take effect on the next clock and must be done while idle.
module dome_shutter_controller #(
   parameter int TICKS_PER_SECOND = dsc_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dsc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dsc_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [dsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dsc_pkg::cfg_type cfg;

   logic                          req_valid_ff, req_valid_in;
   dsc_pkg::req_type              req_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   dsc_pkg::rsp_type              rsp_ff, rsp_step;
   logic [dsc_pkg::STATE_W-1:0]   state_ff, state_in;
   logic [dsc_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                          fire;
   logic                          req_take;

   dsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dsc_step #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_step (
      .req          (req_ff),
      .cfg          (cfg),
      .state        (state_ff),
      .elapsed      (elapsed_ff),
      .state_next   (state_in),
      .elapsed_next (elapsed_in),
      .rsp          (rsp_step)
   );

   // process the held beat when the result register is free or draining
   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= dsc_pkg::ST_ERROR;
         elapsed_ff   <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff   <= state_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_step;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_elapsed_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dsc_pkg::ST_OPENING && state_ff != dsc_pkg::ST_CLOSING)
         |-> (elapsed_ff == '0))
      else $error("elapsed count nonzero while shutter not moving");

   a_refused_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |-> rsp_ff.slewing)
      else $error("refused command reported while not slewing");

   a_abort_error: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.op == dsc_pkg::OP_ABORT)
         |=> (state_ff == dsc_pkg::ST_ERROR && rsp_ff.shutter_state == dsc_pkg::ST_ERROR))
      else $error("abort did not force error state");

endmodule

// ----- hdl/dsc_csr.sv -----
module dsc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dsc_pkg::cfg_type                cfg
);

   dsc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dsc_pkg::CSR_SWITCH_MODE: begin
               cfg_in.switch_mode = csr_wdata[0];
            end
            dsc_pkg::CSR_TIMEOUT_SECONDS: begin
               cfg_in.timeout_seconds = csr_wdata[dsc_pkg::TIMEOUT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.switch_mode     <= 1'b0;
         cfg_ff.timeout_seconds <= dsc_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/dsc_step.sv -----
module dsc_step #(
   parameter int TICKS_PER_SECOND = dsc_pkg::TICKS_PER_SECOND_DEF
) (
   input  dsc_pkg::req_type                    req,
   input  dsc_pkg::cfg_type                    cfg,
   input  logic [dsc_pkg::STATE_W-1:0]         state,
   input  logic [dsc_pkg::ELAPSED_W-1:0]       elapsed,
   output logic [dsc_pkg::STATE_W-1:0]         state_next,
   output logic [dsc_pkg::ELAPSED_W-1:0]       elapsed_next,
   output dsc_pkg::rsp_type                    rsp
);

   localparam int LIMIT_W = dsc_pkg::TIMEOUT_W + $clog2(TICKS_PER_SECOND + 1);
   localparam int CMP_W   = (LIMIT_W > dsc_pkg::ELAPSED_W) ? LIMIT_W : dsc_pkg::ELAPSED_W;

   logic [LIMIT_W-1:0]            limit;
   logic [dsc_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic                          over;
   logic                          moving;
   logic                          accepted;

   assign limit = LIMIT_W'(cfg.timeout_seconds) * LIMIT_W'(TICKS_PER_SECOND);
   assign elapsed_inc = (elapsed == {dsc_pkg::ELAPSED_W{1'b1}}) ? elapsed
                                                                 : elapsed + 1'b1;
   assign over   = CMP_W'(elapsed_inc) > CMP_W'(limit);
   assign moving = (state == dsc_pkg::ST_OPENING) || (state == dsc_pkg::ST_CLOSING);

   always_comb begin
      state_next   = state;
      elapsed_next = elapsed;
      accepted     = 1'b1;
      case (req.op)
         dsc_pkg::OP_TICK: begin
            if (moving) begin
               elapsed_next = elapsed_inc;
               if (cfg.switch_mode) begin
                  if (over) begin
                     state_next   = dsc_pkg::ST_ERROR;
                     elapsed_next = '0;
                  end else if (state == dsc_pkg::ST_OPENING && req.switch_opened) begin
                     state_next   = dsc_pkg::ST_OPEN;
                     elapsed_next = '0;
                  end else if (state == dsc_pkg::ST_CLOSING && req.switch_closed) begin
                     state_next   = dsc_pkg::ST_CLOSED;
                     elapsed_next = '0;
                  end
               end else if (over) begin
                  state_next   = (state == dsc_pkg::ST_OPENING) ? dsc_pkg::ST_OPEN
                                                                : dsc_pkg::ST_CLOSED;
                  elapsed_next = '0;
               end
            end
         end
         dsc_pkg::OP_OPEN: begin
            if (state == dsc_pkg::ST_CLOSING) begin
               accepted = 1'b0;
            end else if (state != dsc_pkg::ST_OPENING) begin
               state_next   = dsc_pkg::ST_OPENING;
               elapsed_next = '0;
            end
         end
         dsc_pkg::OP_CLOSE: begin
            if (state == dsc_pkg::ST_OPENING) begin
               accepted = 1'b0;
            end else if (state != dsc_pkg::ST_CLOSING) begin
               state_next   = dsc_pkg::ST_CLOSING;
               elapsed_next = '0;
            end
         end
         dsc_pkg::OP_ABORT: begin
            state_next   = dsc_pkg::ST_ERROR;
            elapsed_next = '0;
         end
         dsc_pkg::OP_INIT: begin
            if (cfg.switch_mode && req.switch_closed) begin
               state_next = dsc_pkg::ST_CLOSED;
            end else if (cfg.switch_mode && req.switch_opened) begin
               state_next = dsc_pkg::ST_OPEN;
            end else begin
               state_next = dsc_pkg::ST_ERROR;
            end
            elapsed_next = '0;
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      rsp.shutter_state = state_next;
      rsp.relay_open    = (state_next == dsc_pkg::ST_OPENING);
      rsp.relay_close   = (state_next == dsc_pkg::ST_CLOSING);
      rsp.slewing       = rsp.relay_open || rsp.relay_close;
      rsp.accepted      = accepted;
   end

endmodule

// ----- tb/sv/tb_dome_shutter_controller.sv -----
`timescale 1ns / 1ps

module tb_dome_shutter_controller;

   localparam int TICKS = dsc_pkg::TICKS_PER_SECOND_DEF;
   localparam logic [dsc_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [dsc_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [dsc_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dsc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dsc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [dsc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dsc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   dome_shutter_controller u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the controller
   logic [dsc_pkg::STATE_W-1:0] shadow_state = dsc_pkg::ST_ERROR;
   logic [dsc_pkg::ELAPSED_W-1:0] shadow_elapsed = '0;
   logic shadow_use_switches = 1'b0;
   logic [dsc_pkg::TIMEOUT_W-1:0] shadow_timeout = dsc_pkg::TIMEOUT_RESET;

   dsc_pkg::rsp_type pending_status[$];
   int mismatches = 0;
   bit steady = 1'b0;
   int stall_left = 0;

   typedef struct packed {
      bit is_csr;
      logic [dsc_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [dsc_pkg::CSR_DATA_W-1:0] csr_val;
      dsc_pkg::req_type beat;
      bit typed;
      dsc_pkg::rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic dsc_pkg::rsp_type shutter_next(input dsc_pkg::req_type r);
      dsc_pkg::rsp_type o;
      logic acc;
      logic over;
      logic [dsc_pkg::STATE_W-1:0] tgt;
      logic [dsc_pkg::STATE_W-1:0] opp;
      int limit;
      acc = 1'b1;
      case (r.op)
         dsc_pkg::OP_TICK: begin
            if (shadow_state == dsc_pkg::ST_OPENING || shadow_state == dsc_pkg::ST_CLOSING) begin
               if (shadow_elapsed != '1) shadow_elapsed = shadow_elapsed + 1'b1;
               limit = int'(shadow_timeout) * TICKS;
               over = int'(shadow_elapsed) > limit;
               if (shadow_use_switches) begin
                  if (over) begin
                     shadow_state = dsc_pkg::ST_ERROR;
                     shadow_elapsed = '0;
                  end else if (shadow_state == dsc_pkg::ST_OPENING && r.switch_opened) begin
                     shadow_state = dsc_pkg::ST_OPEN;
                     shadow_elapsed = '0;
                  end else if (shadow_state == dsc_pkg::ST_CLOSING && r.switch_closed) begin
                     shadow_state = dsc_pkg::ST_CLOSED;
                     shadow_elapsed = '0;
                  end
               end else if (over) begin
                  shadow_state = (shadow_state == dsc_pkg::ST_OPENING) ? dsc_pkg::ST_OPEN
                                                                       : dsc_pkg::ST_CLOSED;
                  shadow_elapsed = '0;
               end
            end
         end
         dsc_pkg::OP_OPEN, dsc_pkg::OP_CLOSE: begin
            tgt = (r.op == dsc_pkg::OP_OPEN) ? dsc_pkg::ST_OPENING : dsc_pkg::ST_CLOSING;
            opp = (r.op == dsc_pkg::OP_OPEN) ? dsc_pkg::ST_CLOSING : dsc_pkg::ST_OPENING;
            if (shadow_state == opp) begin
               acc = 1'b0;
            end else if (shadow_state != tgt) begin
               shadow_state = tgt;
               shadow_elapsed = '0;
            end
         end
         dsc_pkg::OP_ABORT: begin
            shadow_state = dsc_pkg::ST_ERROR;
            shadow_elapsed = '0;
         end
         dsc_pkg::OP_INIT: begin
            if (shadow_use_switches && r.switch_closed) shadow_state = dsc_pkg::ST_CLOSED;
            else if (shadow_use_switches && r.switch_opened) shadow_state = dsc_pkg::ST_OPEN;
            else shadow_state = dsc_pkg::ST_ERROR;
            shadow_elapsed = '0;
         end
         default: begin
         end
      endcase
      o.shutter_state = shadow_state;
      o.slewing = (shadow_state == dsc_pkg::ST_OPENING || shadow_state == dsc_pkg::ST_CLOSING);
      o.relay_open = (shadow_state == dsc_pkg::ST_OPENING);
      o.relay_close = (shadow_state == dsc_pkg::ST_CLOSING);
      o.accepted = acc;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic cmp_field(input string name, input logic [2:0] got, input logic [2:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic check_status(input dsc_pkg::rsp_type got);
      dsc_pkg::rsp_type want;
      if (pending_status.size() == 0) begin
         report_mismatch("result beat with nothing pending");
         return;
      end
      want = pending_status.pop_front();
      cmp_field("shutter_state", got.shutter_state, want.shutter_state);
      cmp_field("slewing", 3'(got.slewing), 3'(want.slewing));
      cmp_field("relay_open", 3'(got.relay_open), 3'(want.relay_open));
      cmp_field("relay_close", 3'(got.relay_close), 3'(want.relay_close));
      cmp_field("accepted", 3'(got.accepted), 3'(want.accepted));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_status(rsp_data);
            stall_left = steady ? 0 : $urandom_range(0, 7);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic drive_beat(input dsc_pkg::req_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_beat(input dsc_pkg::req_type r);
      drive_beat(r);
      pending_status.push_back(shutter_next(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dsc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dsc_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == dsc_pkg::CSR_SWITCH_MODE) shadow_use_switches = val[0];
      else shadow_timeout = val[dsc_pkg::TIMEOUT_W-1:0];
   endtask

   task automatic configure(input logic use_sw, input logic [dsc_pkg::TIMEOUT_W-1:0] tmo);
      logic [dsc_pkg::CSR_DATA_W-1:0] val;
      wait_idle();
      val = dsc_pkg::CSR_DATA_W'($urandom);
      val[0] = use_sw;
      write_csr(dsc_pkg::CSR_SWITCH_MODE, val);
      @(posedge clock);
      write_csr(dsc_pkg::CSR_TIMEOUT_SECONDS, dsc_pkg::CSR_DATA_W'(tmo));
   endtask

   function automatic dsc_pkg::req_type make_req(input logic [dsc_pkg::OP_W-1:0] op,
                                                 input logic sc, input logic so);
      dsc_pkg::req_type r;
      r.op = op;
      r.switch_closed = sc;
      r.switch_opened = so;
      return r;
   endfunction

   function automatic void add_beat(input logic [dsc_pkg::OP_W-1:0] op, input logic sc,
                                    input logic so);
      dir_row_type row;
      row = '0;
      row.beat = make_req(op, sc, so);
      dir_rows.push_back(row);
   endfunction

   function automatic void add_fixed(input logic [dsc_pkg::OP_W-1:0] op, input logic sc,
                                     input logic so,
                                     input logic [dsc_pkg::STATE_W-1:0] st, input logic sl,
                                     input logic ro, input logic rc, input logic acc);
      dir_row_type row;
      row = '0;
      row.beat = make_req(op, sc, so);
      row.typed = 1'b1;
      row.want.shutter_state = st;
      row.want.slewing = sl;
      row.want.relay_open = ro;
      row.want.relay_close = rc;
      row.want.accepted = acc;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [dsc_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [dsc_pkg::CSR_DATA_W-1:0] val);
      dir_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      dir_rows.push_back(row);
   endfunction

   function automatic dsc_pkg::req_type random_req();
      int pick;
      logic [dsc_pkg::OP_W-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = dsc_pkg::OP_TICK;
      else if (pick < 60) op = dsc_pkg::OP_OPEN;
      else if (pick < 75) op = dsc_pkg::OP_CLOSE;
      else if (pick < 80) op = dsc_pkg::OP_ABORT;
      else if (pick < 92) op = dsc_pkg::OP_INIT;
      else op = dsc_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      return make_req(op, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == n / 2) wait_idle();
         send_beat(random_req());
      end
   endtask

   // full-length move with a repeated command half way; switches stay low
   task automatic long_move(input logic [dsc_pkg::OP_W-1:0] op, input int n_ticks);
      send_beat(make_req(dsc_pkg::OP_ABORT, 1'b0, 1'b0));
      send_beat(make_req(op, 1'b0, 1'b0));
      for (int i = 0; i < n_ticks; i++) begin
         if (i == n_ticks / 2) send_beat(make_req(op, 1'b0, 1'b0));
         send_beat(make_req(dsc_pkg::OP_TICK, 1'b0, 1'b0));
      end
   endtask

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      dsc_pkg::rsp_type predicted;
      int k;

      // after reset: timer mode, 60 s
      add_fixed(dsc_pkg::OP_TICK, 1'b0, 1'b0, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_INIT, 1'b1, 1'b0, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_OPEN, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_OPEN, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_CLOSE, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b0);
      add_fixed(OP_SPARE_LO, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_TICK, 1'b1, 1'b1, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_ABORT, 1'b0, 1'b0, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_CLOSE, 1'b0, 1'b0, dsc_pkg::ST_CLOSING, 1'b1, 1'b0, 1'b1, 1'b1);
      add_fixed(dsc_pkg::OP_OPEN, 1'b0, 1'b0, dsc_pkg::ST_CLOSING, 1'b1, 1'b0, 1'b1, 1'b0);
      add_beat(OP_SPARE_HI, 1'b1, 1'b1);
      // switch mode, zero timeout
      add_csr(dsc_pkg::CSR_SWITCH_MODE, 9'h1FF);
      add_csr(dsc_pkg::CSR_TIMEOUT_SECONDS, 9'd0);
      add_fixed(dsc_pkg::OP_INIT, 1'b1, 1'b1, dsc_pkg::ST_CLOSED, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_CLOSE, 1'b0, 1'b0, dsc_pkg::ST_CLOSING, 1'b1, 1'b0, 1'b1, 1'b1);
      add_fixed(dsc_pkg::OP_TICK, 1'b0, 1'b1, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_INIT, 1'b0, 1'b1, dsc_pkg::ST_OPEN, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_OPEN, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_TICK, 1'b1, 1'b1, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_INIT, 1'b0, 1'b0, dsc_pkg::ST_ERROR, 1'b0, 1'b0, 1'b0, 1'b1);
      // switch mode, widest timeout
      add_csr(dsc_pkg::CSR_TIMEOUT_SECONDS, 9'd511);
      add_fixed(dsc_pkg::OP_OPEN, 1'b0, 1'b0, dsc_pkg::ST_OPENING, 1'b1, 1'b1, 1'b0, 1'b1);
      add_beat(dsc_pkg::OP_TICK, 1'b1, 1'b0);
      add_fixed(dsc_pkg::OP_TICK, 1'b0, 1'b1, dsc_pkg::ST_OPEN, 1'b0, 1'b0, 1'b0, 1'b1);
      add_fixed(dsc_pkg::OP_CLOSE, 1'b0, 1'b0, dsc_pkg::ST_CLOSING, 1'b1, 1'b0, 1'b1, 1'b1);
      add_fixed(dsc_pkg::OP_TICK, 1'b1, 1'b1, dsc_pkg::ST_CLOSED, 1'b0, 1'b0, 1'b0, 1'b1);
      add_beat(OP_SPARE_MID, 1'b0, 1'b1);
      add_csr(dsc_pkg::CSR_SWITCH_MODE, 9'h000);
      add_beat(dsc_pkg::OP_OPEN, 1'b0, 1'b0);
      add_beat(dsc_pkg::OP_TICK, 1'b1, 1'b1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            wait_idle();
            write_csr(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            drive_beat(dir_rows[i].beat);
            predicted = shutter_next(dir_rows[i].beat);
            pending_status.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
         end
      end

      configure(1'b1, 9'd511);
      run_random(55);
      configure(1'b0, 9'd0);
      run_random(55);
      configure(1'b1, 9'd0);
      run_random(55);
      configure(1'b0, 9'd300);
      run_random(55);

      // overrun error in switch mode just past the one-second limit
      configure(1'b1, 9'd1);
      steady = 1'b1;
      long_move(dsc_pkg::OP_OPEN, TICKS + 2);
      steady = 1'b0;

      req_valid <= 1'b0;
      for (k = 0; k < 1000 && pending_status.size() != 0; k++) @(posedge clock);
      repeat (5) @(posedge clock);
      if (pending_status.size() != 0) report_mismatch("results missing at end of run");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
